// ===== rtl/sctv_pkg.sv =====
// shared constants, types and codes for the sorted coordinate table
package sctv_pkg;

    localparam int ENTRIES     = 256;
    localparam int INDEX_BITS  = 20;
    localparam int VALUE_BITS  = 32;
    localparam int KEY_BITS    = 2 * INDEX_BITS;
    localparam int LIMIT_BITS  = 21;
    localparam int COUNT_BITS  = $clog2(ENTRIES + 1);
    localparam int GROUP_SIZE  = 16;
    localparam int GROUPS      = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int OUT_BITS    = 32;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic REG_ROW_LIMIT    = 1'b0;
    localparam logic REG_COLUMN_LIMIT = 1'b1;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1 << INDEX_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                  cmp_en;
        logic                  ins;
        logic                  wr;
        logic [KEY_BITS-1:0]   probe;
        logic [VALUE_BITS-1:0] new_value;
    } cell_ctl_t;

endpackage

// ===== rtl/sctv_cell.sv =====
// one table cell: holds a key and value, compares, shifts right on insert and overwrites its value on a write hit
module sctv_cell (
    input  logic                           clk,
    input  sctv_pkg::cell_ctl_t            ctl,
    input  logic                           occupied,
    input  logic [sctv_pkg::KEY_BITS-1:0]   left_key,
    input  logic [sctv_pkg::VALUE_BITS-1:0] left_value,
    input  logic                           left_lt,
    output logic [sctv_pkg::KEY_BITS-1:0]   key,
    output logic [sctv_pkg::VALUE_BITS-1:0] value,
    output logic                           lt,
    output logic                           eq,
    output logic [sctv_pkg::VALUE_BITS-1:0] hit_value
);
    import sctv_pkg::*;

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  lt_reg;
    logic                  eq_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            lt_reg <= occupied && (key_reg < ctl.probe);
            eq_reg <= occupied && (key_reg == ctl.probe);
        end
        if (ctl.ins)
        begin
            if (!lt_reg && left_lt)
            begin
                key_reg   <= ctl.probe;
                value_reg <= ctl.new_value;
            end
            else if (!lt_reg)
            begin
                key_reg   <= left_key;
                value_reg <= left_value;
            end
        end
        else if (ctl.wr && eq_reg)
        begin
            value_reg <= ctl.new_value;
        end
    end

    assign key       = key_reg;
    assign value     = value_reg;
    assign lt        = lt_reg;
    assign eq        = eq_reg;
    assign hit_value = eq_reg ? value_reg : '0;

endmodule

// ===== rtl/sorted_coordinate_value_table_core.sv =====
// sorted coordinate table: sequencer, row of cells and result register
// steps per item: compare, group reduce, execute, then return to idle; the result is registered in execute
// a new input beat is taken only in idle, so not before the last item is done
// the execute step waits while a finished result is still stalled at the output
// reset: async active low; table empties, limits go to 1048576, no result pending
module sorted_coordinate_value_table_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic [sctv_pkg::INDEX_BITS-1:0]    row,
    input  logic [sctv_pkg::INDEX_BITS-1:0]    column,
    input  logic signed [31:0]                write_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sctv_pkg::OUT_BITS-1:0] read_value,
    output logic                              was_present,
    output logic [1:0]                        status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [sctv_pkg::LIMIT_BITS-1:0]    cfg_data
);
    import sctv_pkg::*;

    state_t                  state_reg, state_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [LIMIT_BITS-1:0]   row_limit_reg, column_limit_reg;
    logic [1:0]              kind_reg;
    logic [INDEX_BITS-1:0]   row_reg, column_reg;
    logic [VALUE_BITS-1:0]   wval_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]     rv_reg, rv_next;
    logic                    wp_reg, wp_next;
    logic [1:0]              st_reg, st_next;

    logic [KEY_BITS-1:0]     key_vec [ENTRIES];
    logic [VALUE_BITS-1:0]   val_vec [ENTRIES];
    logic [VALUE_BITS-1:0]   hit_vec [ENTRIES];
    logic [ENTRIES-1:0]      lt_vec;
    logic [ENTRIES-1:0]      eq_vec;
    logic [ENTRIES-1:0]      occ_vec;

    logic [GROUPS-1:0]       grp_eq_reg, grp_eq_next;
    logic [VALUE_BITS-1:0]   grp_val_reg [GROUPS];
    logic [VALUE_BITS-1:0]   grp_val_next [GROUPS];

    cell_ctl_t               ctl;
    logic                    out_free;
    logic                    present;
    logic [VALUE_BITS-1:0]   hit_val;
    logic                    is_contains;
    logic                    is_write;
    logic                    idx_over;
    logic                    is_full;
    logic                    do_ins;
    logic                    do_wr;
    logic                    in_beat;

    assign in_beat   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // cell row
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   lkey;
        logic [VALUE_BITS-1:0] lval;
        logic                  llt;

        if (i == 0)
        begin : g_first
            assign lkey = ctl.probe;
            assign lval = ctl.new_value;
            assign llt  = 1'b1;
        end
        else
        begin : g_rest
            assign lkey = key_vec[i-1];
            assign lval = val_vec[i-1];
            assign llt  = lt_vec[i-1];
        end

        assign occ_vec[i] = (COUNT_BITS'(i) < count_reg);

        sctv_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (occ_vec[i]),
            .left_key   (lkey),
            .left_value (lval),
            .left_lt    (llt),
            .key        (key_vec[i]),
            .value      (val_vec[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i]),
            .hit_value  (hit_vec[i])
        );
    end

    // group reduction of hit flags and values
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_eq_next[g]  = 1'b0;
            grp_val_next[g] = '0;
            for (int m = 0; m < GROUP_SIZE; m++)
            begin
                if (g * GROUP_SIZE + m < ENTRIES)
                begin
                    grp_eq_next[g]  = grp_eq_next[g] | eq_vec[g * GROUP_SIZE + m];
                    grp_val_next[g] = grp_val_next[g] | hit_vec[g * GROUP_SIZE + m];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RED)
        begin
            grp_eq_reg  <= grp_eq_next;
            grp_val_reg <= grp_val_next;
        end
    end

    always_comb
    begin
        hit_val = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            hit_val = hit_val | grp_val_reg[g];
        end
    end

    assign present      = |grp_eq_reg;
    assign is_contains  = kind_reg[1];
    assign is_write     = (kind_reg == KIND_WRITE);
    assign idx_over     = ({1'b0, row_reg} >= row_limit_reg)
                       || ({1'b0, column_reg} >= column_limit_reg);
    assign is_full      = (count_reg == COUNT_BITS'(ENTRIES));

    // captured beat
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            kind_reg   <= kind;
            row_reg    <= row;
            column_reg <= column;
            wval_reg   <= VALUE_BITS'(write_value);
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC && out_free)
        begin
            rv_reg <= rv_next;
            wp_reg <= wp_next;
            st_reg <= st_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg    <= LIMIT_RESET;
            column_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_LIMIT:    row_limit_reg    <= cfg_data;
                REG_COLUMN_LIMIT: column_limit_reg <= cfg_data;
                default:          row_limit_reg    <= row_limit_reg;
            endcase
        end
    end

    // next state and execute decision
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        rv_next        = '0;
        wp_next        = 1'b0;
        st_next        = STATUS_OK;
        do_ins         = 1'b0;
        do_wr          = 1'b0;

        if (is_contains)
        begin
            wp_next = present;
            rv_next = OUT_BITS'(hit_val);
        end
        else if (idx_over)
        begin
            st_next = STATUS_RANGE;
        end
        else if (present)
        begin
            wp_next = 1'b1;
            do_wr   = is_write;
            rv_next = is_write ? OUT_BITS'(wval_reg) : OUT_BITS'(hit_val);
        end
        else if (is_full)
        begin
            st_next = STATUS_FULL;
        end
        else
        begin
            do_ins  = 1'b1;
            rv_next = is_write ? OUT_BITS'(wval_reg) : '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (do_ins)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.cmp_en    = (state_reg == ST_CMP);
        ctl.ins       = (state_reg == ST_EXEC) && out_free && do_ins;
        ctl.wr        = (state_reg == ST_EXEC) && out_free && do_wr;
        ctl.probe     = {row_reg, column_reg};
        ctl.new_value = is_write ? wval_reg : '0;
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = rv_reg;
    assign was_present = wp_reg;
    assign status      = st_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(ENTRIES))
        else $error("entry count above table size");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |-> $onehot0(eq_vec))
        else $error("more than one cell matches the probe");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && st_reg == STATUS_FULL |-> count_reg == COUNT_BITS'(ENTRIES))
        else $error("full status with room left");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> state_reg == ST_CMP)
        else $error("beat taken but compare not started");

endmodule
